### rtl/core/assert_macros.svh
// Concurrent assertion helpers, clocked on clk and quiet while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define ASSERT_IMPL(label, ante, cons, msg) \
  `ASSERT_RST(label, (ante) |-> (cons), msg)

`endif

### rtl/core/ihd_pkg.sv
package ihd_pkg;

  localparam int unsigned HDR_LEN = 16;

  localparam logic [7:0] MAGIC_0 = 8'h4E;
  localparam logic [7:0] MAGIC_1 = 8'h45;
  localparam logic [7:0] MAGIC_2 = 8'h53;
  localparam logic [7:0] MAGIC_3 = 8'h1A;

  localparam logic [7:0] FMT_MASK  = 8'h0C;
  localparam logic [7:0] FMT_NES2  = 8'h08;
  localparam logic [3:0] EXP_NIB   = 4'hF;

  localparam int unsigned PRG_UNIT_SHIFT = 14;
  localparam int unsigned CHR_UNIT_SHIFT = 13;
  localparam logic [8:0]  PRG_ZERO_BANKS = 9'd256;
  localparam int unsigned TRAINER_BYTES  = 512;

  localparam int unsigned MID_DEPTH_DEF = 2;
  localparam int unsigned OUT_DEPTH_DEF = 2;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_SHORT    = 2'd1,
    STATUS_BAD_MAGIC = 2'd2,
    STATUS_BAD_SIZE = 2'd3
  } status_t;

  // Full header, byte 0 in the lowest lane.
  typedef logic [HDR_LEN-1:0][7:0] header_t;

  typedef struct packed {
    status_t     status;
    logic [11:0] mapper_number;
    logic [31:0] prg_size;
    logic [31:0] chr_size;
    logic [7:0]  flags_six;
    logic [7:0]  flags_seven;
    logic        is_nes2;
  } result_t;

endpackage

### rtl/core/ihd_fifo.sv
`include "assert_macros.svh"

module ihd_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  `ASSERT_RST(a_count_bound, count <= CNT_W'(DEPTH), "fifo count beyond depth")
  `ASSERT_IMPL(a_push_shows, do_push && !do_pop, ##1 !empty, "pushed beat not visible")

endmodule

### rtl/core/ihd_front.sv
`include "assert_macros.svh"

module ihd_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic             stall,
  input  logic [7:0]       header_byte,
  input  logic             start_of_header,
  output logic             rec_push,
  output ihd_pkg::header_t rec
);

  localparam int unsigned STORE_N = ihd_pkg::HDR_LEN - 1;
  localparam int unsigned IDX_W   = $clog2(STORE_N);
  localparam logic [4:0]  POS_END = 5'(ihd_pkg::HDR_LEN);
  localparam logic [4:0]  POS_LAST = 5'(ihd_pkg::HDR_LEN - 1);

  logic [7:0] store [STORE_N];
  logic [4:0] byte_position;
  logic [4:0] byte_position_next;
  logic [4:0] pos;
  logic       accept;
  logic       in_hdr;

  assign accept   = push && !stall;
  assign pos      = start_of_header ? 5'd0 : byte_position;
  assign in_hdr   = (pos < POS_END);
  assign rec_push = accept && (pos == POS_LAST);
  assign byte_position_next = in_hdr ? pos + 5'd1 : POS_END;

  always_comb begin
    for (int i = 0; i < STORE_N; i++) begin
      rec[i] = store[i];
    end
    rec[STORE_N] = header_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
    end else if (accept) begin
      byte_position <= byte_position_next;
    end
  end

  // Last byte goes straight into the record, so only the first fifteen are kept.
  always_ff @(posedge clk) begin
    if (accept && in_hdr && pos != POS_LAST) begin
      store[pos[IDX_W-1:0]] <= header_byte;
    end
  end

  `ASSERT_RST(a_pos_bound, byte_position <= POS_END, "byte position past end")
  `ASSERT_IMPL(a_done_park, rec_push, ##1 byte_position == POS_END,
    "position not parked after last byte")

endmodule

### rtl/core/ihd_back.sv
`include "assert_macros.svh"

module ihd_back (
  input  logic             clk,
  input  logic             rst,
  input  logic [31:0]      file_size,
  input  logic             rec_empty,
  input  ihd_pkg::header_t rec,
  output logic             rec_pop,
  input  logic             res_full,
  output logic             res_push,
  output ihd_pkg::result_t res
);

  typedef struct packed {
    logic        ok;
    logic [31:0] bytes;
  } size_dec_t;

  // NES 2.0 size field: plain count times unit, or exponent-multiplier form.
  function automatic size_dec_t nes2_size(input logic [7:0] lsb, input logic [3:0] nib,
                                          input logic is_prg);
    size_dec_t   d;
    logic [34:0] val;
    logic [34:0] cnt;
    d.ok = 1'b1;
    d.bytes = '0;
    if (nib != ihd_pkg::EXP_NIB) begin
      cnt = {23'd0, nib, lsb};
      val = is_prg ? (cnt << ihd_pkg::PRG_UNIT_SHIFT) : (cnt << ihd_pkg::CHR_UNIT_SHIFT);
    end else begin
      cnt = {32'd0, lsb[1:0], 1'b1};
      val = cnt << lsb[6:2];
      if (lsb[7]) begin
        d.ok = 1'b0;
      end
    end
    if (val[34:32] != 3'd0) begin
      d.ok = 1'b0;
    end
    if (d.ok) begin
      d.bytes = val[31:0];
    end
    return d;
  endfunction

  typedef struct packed {
    ihd_pkg::status_t pre_status;
    logic             size_ok;
    logic             trainer;
    logic [11:0]      mapper_number;
    logic [31:0]      prg_size;
    logic [31:0]      chr_size;
    logic [7:0]       flags_six;
    logic [7:0]       flags_seven;
    logic             is_nes2;
  } stage_t;

  stage_t      s1;
  stage_t      s1_next;
  logic        s1_valid;
  logic        s1_load;
  size_dec_t   prg_dec;
  size_dec_t   chr_dec;
  logic [8:0]  prg_banks;
  logic        archaic;
  logic [33:0] expected;
  logic        fits;

  assign res_push = s1_valid && !res_full;
  assign s1_load  = !rec_empty && (!s1_valid || res_push);
  assign rec_pop  = s1_load;

  // Classify and size the header.
  always_comb begin
    s1_next   = '0;
    prg_dec   = nes2_size(rec[4], rec[9][3:0], 1'b1);
    chr_dec   = nes2_size(rec[5], rec[9][7:4], 1'b0);
    prg_banks = (rec[4] == 8'd0) ? ihd_pkg::PRG_ZERO_BANKS : {1'b0, rec[4]};
    archaic   = (rec[12] | rec[13] | rec[14] | rec[15]) != 8'd0;

    s1_next.flags_six   = rec[6];
    s1_next.flags_seven = rec[7];
    s1_next.is_nes2     = (rec[7] & ihd_pkg::FMT_MASK) == ihd_pkg::FMT_NES2;
    s1_next.trainer     = rec[6][2];
    if (s1_next.is_nes2) begin
      s1_next.mapper_number = {rec[8][3:0], rec[7][7:4], rec[6][7:4]};
      s1_next.prg_size      = prg_dec.bytes;
      s1_next.chr_size      = chr_dec.bytes;
      s1_next.size_ok       = prg_dec.ok && chr_dec.ok && (prg_dec.bytes != 32'd0);
    end else begin
      s1_next.mapper_number = {4'd0, archaic ? 4'd0 : rec[7][7:4], rec[6][7:4]};
      s1_next.prg_size      = {9'd0, prg_banks, 14'd0};
      s1_next.chr_size      = {11'd0, rec[5], 13'd0};
      s1_next.size_ok       = 1'b1;
    end

    if (file_size < 32'(ihd_pkg::HDR_LEN)) begin
      s1_next.pre_status = ihd_pkg::STATUS_SHORT;
    end else if (rec[0] != ihd_pkg::MAGIC_0 || rec[1] != ihd_pkg::MAGIC_1 ||
                 rec[2] != ihd_pkg::MAGIC_2 || rec[3] != ihd_pkg::MAGIC_3) begin
      s1_next.pre_status = ihd_pkg::STATUS_BAD_MAGIC;
    end else begin
      s1_next.pre_status = ihd_pkg::STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_load) begin
      s1_valid <= 1'b1;
    end else if (res_push) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1 <= s1_next;
    end
  end

  // Length check: header, optional trainer, PRG and CHR must fit in the image.
  assign expected = 34'(ihd_pkg::HDR_LEN) +
                    (s1.trainer ? 34'(ihd_pkg::TRAINER_BYTES) : 34'd0) +
                    {2'd0, s1.prg_size} + {2'd0, s1.chr_size};
  assign fits = expected <= {2'd0, file_size};

  always_comb begin
    res = '0;
    case (s1.pre_status)
      ihd_pkg::STATUS_SHORT:     res.status = ihd_pkg::STATUS_SHORT;
      ihd_pkg::STATUS_BAD_MAGIC: res.status = ihd_pkg::STATUS_BAD_MAGIC;
      default: begin
        res.mapper_number = s1.mapper_number;
        res.flags_six     = s1.flags_six;
        res.flags_seven   = s1.flags_seven;
        res.is_nes2       = s1.is_nes2;
        if (s1.size_ok && fits) begin
          res.status   = ihd_pkg::STATUS_OK;
          res.prg_size = s1.prg_size;
          res.chr_size = s1.chr_size;
        end else begin
          res.status = ihd_pkg::STATUS_BAD_SIZE;
        end
      end
    endcase
  end

  `ASSERT_IMPL(a_s1_hold, s1_valid && !res_push, ##1 s1_valid, "decoded header dropped")
  `ASSERT_IMPL(a_pop_fill, rec_pop, ##1 s1_valid, "popped record not staged")

endmodule

### rtl/core/ines_header_decoder_top.sv
// Header decoder: one header byte accepted per cycle while full is low.
// A result goes through the record queue, stage s1 and the result queue.
// Throughput: one byte per cycle unless full, one result per sixteen-byte header.
// full follows the record queue between the byte collector and the decoder.
// Reset (rst, synchronous, active high) clears file_size, byte position and queues.
module ines_header_decoder_top #(
  parameter int unsigned MID_DEPTH = ihd_pkg::MID_DEPTH_DEF,
  parameter int unsigned OUT_DEPTH = ihd_pkg::OUT_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  header_byte,
  input  logic        start_of_header,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  status,
  output logic [11:0] mapper_number,
  output logic [31:0] prg_size,
  output logic [31:0] chr_size,
  output logic [7:0]  flags_six,
  output logic [7:0]  flags_seven,
  output logic        is_nes2,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);

  localparam int unsigned HDR_W = $bits(ihd_pkg::header_t);
  localparam int unsigned RES_W = $bits(ihd_pkg::result_t);

  logic [31:0]      file_size;
  logic             rec_push;
  ihd_pkg::header_t rec_in;
  ihd_pkg::header_t rec_out;
  logic             rec_full;
  logic             rec_empty;
  logic             rec_pop;
  logic             res_push;
  logic             res_full;
  ihd_pkg::result_t res_in;
  ihd_pkg::result_t res_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      file_size <= '0;
    end else if (cfg_we) begin
      file_size <= cfg_wdata;
    end
  end

  assign full = rec_full;

  ihd_front u_front (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .stall           (rec_full),
    .header_byte     (header_byte),
    .start_of_header (start_of_header),
    .rec_push        (rec_push),
    .rec             (rec_in)
  );

  ihd_fifo #(
    .WIDTH (HDR_W),
    .DEPTH (MID_DEPTH)
  ) u_rec_q (
    .clk   (clk),
    .rst   (rst),
    .push  (rec_push),
    .wdata (rec_in),
    .full  (rec_full),
    .pop   (rec_pop),
    .rdata (rec_out),
    .empty (rec_empty)
  );

  ihd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .file_size (file_size),
    .rec_empty (rec_empty),
    .rec       (rec_out),
    .rec_pop   (rec_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  ihd_fifo #(
    .WIDTH (RES_W),
    .DEPTH (OUT_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_out),
    .empty (empty)
  );

  assign status        = res_out.status;
  assign mapper_number = res_out.mapper_number;
  assign prg_size      = res_out.prg_size;
  assign chr_size      = res_out.chr_size;
  assign flags_six     = res_out.flags_six;
  assign flags_seven   = res_out.flags_seven;
  assign is_nes2       = res_out.is_nes2;

endmodule

### test/ines_header_decoder_checker.sv
module ines_header_decoder_checker
  import ihd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        full,
  input  logic [7:0]  header_byte,
  input  logic        start_of_header,
  input  logic        empty,
  input  logic        pop,
  input  logic [1:0]  status,
  input  logic [11:0] mapper_number,
  input  logic [31:0] prg_size,
  input  logic [31:0] chr_size,
  input  logic [7:0]  flags_six,
  input  logic [7:0]  flags_seven,
  input  logic        is_nes2,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  output int          errors,
  output int          pending
);

  localparam logic [63:0] MAX_U32 = 64'hFFFF_FFFF;

  logic [31:0] file_size_q;
  logic [4:0]  next_pos;
  header_t     hdr;
  result_t     decoded_headers[$];

  // NES 2.0 size field; anything above MAX_U32 marks an unusable size.
  function automatic logic [63:0] nes2_rom_bytes(input logic [7:0] lsb, input logic [3:0] nib,
                                                 input int unsigned unit_shift);
    int unsigned ex;
    if (nib != EXP_NIB) return {52'd0, nib, lsb} << unit_shift;
    ex = 32'(lsb[7:2]);
    if (ex >= 32) return '1;
    return (64'd1 << ex) * (64'(lsb[1:0]) * 2 + 1);
  endfunction

  function automatic result_t decode_header(input header_t h, input logic [31:0] fsize);
    result_t     r;
    bit          fits;
    bit          archaic;
    logic [63:0] prg;
    logic [63:0] chr;
    logic [63:0] need;
    r = '0;
    if (fsize < HDR_LEN) begin
      r.status = STATUS_SHORT;
      return r;
    end
    if (h[0] != MAGIC_0 || h[1] != MAGIC_1 || h[2] != MAGIC_2 || h[3] != MAGIC_3) begin
      r.status = STATUS_BAD_MAGIC;
      return r;
    end
    r.flags_six   = h[6];
    r.flags_seven = h[7];
    r.is_nes2     = (h[7] & FMT_MASK) == FMT_NES2;
    if (r.is_nes2) begin
      r.mapper_number = {h[8][3:0], h[7][7:4], h[6][7:4]};
      prg  = nes2_rom_bytes(h[4], h[9][3:0], PRG_UNIT_SHIFT);
      chr  = nes2_rom_bytes(h[5], h[9][7:4], CHR_UNIT_SHIFT);
      fits = prg <= MAX_U32 && chr <= MAX_U32 && prg != 0;
    end else begin
      // Junk in bytes 12..15 means an old header: drop the mapper high nibble.
      archaic = (h[12] | h[13] | h[14] | h[15]) != 0;
      r.mapper_number = {4'h0, archaic ? 4'h0 : h[7][7:4], h[6][7:4]};
      prg  = (h[4] == 0 ? 64'(PRG_ZERO_BANKS) : 64'(h[4])) << PRG_UNIT_SHIFT;
      chr  = 64'(h[5]) << CHR_UNIT_SHIFT;
      fits = 1'b1;
    end
    if (fits) begin
      need = 64'(HDR_LEN) + (h[6][2] ? 64'(TRAINER_BYTES) : 64'd0) + prg + chr;
      fits = need <= 64'(fsize);
    end
    if (!fits) begin
      r.status = STATUS_BAD_SIZE;
      return r;
    end
    r.status   = STATUS_OK;
    r.prg_size = prg[31:0];
    r.chr_size = chr[31:0];
    return r;
  endfunction

  task automatic take_byte(input logic [7:0] b, input logic restart);
    logic [4:0] pos;
    pos = restart ? 5'd0 : next_pos;
    if (pos >= HDR_LEN) begin
      next_pos = 5'(HDR_LEN);
    end else begin
      hdr[pos] = b;
      next_pos = pos + 5'd1;
      if (pos == HDR_LEN - 1) decoded_headers.push_back(decode_header(hdr, file_size_q));
    end
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endtask

  task automatic check_result();
    result_t want;
    if (decoded_headers.size() == 0) begin
      $error("result beat with no decoded header waiting");
      errors++;
      return;
    end
    want = decoded_headers.pop_front();
    compare_field("status", 32'(want.status), 32'(status));
    compare_field("mapper_number", 32'(want.mapper_number), 32'(mapper_number));
    compare_field("prg_size", want.prg_size, prg_size);
    compare_field("chr_size", want.chr_size, chr_size);
    compare_field("flags_six", 32'(want.flags_six), 32'(flags_six));
    compare_field("flags_seven", 32'(want.flags_seven), 32'(flags_seven));
    compare_field("is_nes2", 32'(want.is_nes2), 32'(is_nes2));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      file_size_q = '0;
      next_pos    = '0;
      decoded_headers.delete();
      errors      = 0;
    end else begin
      if (cfg_we) file_size_q = cfg_wdata;
      if (push && !full) take_byte(header_byte, start_of_header);
      if (pop && !empty) check_result();
    end
    pending = decoded_headers.size();
  end

endmodule

### test/tb_ines_header_decoder_top.sv
module tb_ines_header_decoder_top;
  import ihd_pkg::*;

  localparam int ITEMS       = 1450;
  localparam int HOLD_CYCLES = 400;
  localparam int IDLE_LIMIT  = 3000;

  logic        clk = 1'b0;
  logic        rst;
  logic        push;
  logic        full;
  logic [7:0]  header_byte;
  logic        start_of_header;
  logic        empty;
  logic        pop;
  logic [1:0]  status;
  logic [11:0] mapper_number;
  logic [31:0] prg_size;
  logic [31:0] chr_size;
  logic [7:0]  flags_six;
  logic [7:0]  flags_seven;
  logic        is_nes2;
  logic        cfg_we;
  logic [31:0] cfg_wdata;

  int errors;
  int pending;
  int beats_sent;
  int steady_left;
  int idle_cycles;
  bit hold_request;

  always #1 clk = ~clk;

  ines_header_decoder_top i_dut (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .header_byte     (header_byte),
    .start_of_header (start_of_header),
    .empty           (empty),
    .pop             (pop),
    .status          (status),
    .mapper_number   (mapper_number),
    .prg_size        (prg_size),
    .chr_size        (chr_size),
    .flags_six       (flags_six),
    .flags_seven     (flags_seven),
    .is_nes2         (is_nes2),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata)
  );

  ines_header_decoder_checker i_checker (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .header_byte     (header_byte),
    .start_of_header (start_of_header),
    .empty           (empty),
    .pop             (pop),
    .status          (status),
    .mapper_number   (mapper_number),
    .prg_size        (prg_size),
    .chr_size        (chr_size),
    .flags_six       (flags_six),
    .flags_seven     (flags_seven),
    .is_nes2         (is_nes2),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .errors          (errors),
    .pending         (pending)
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic header_t build_header(input logic [7:0] b4, input logic [7:0] b5,
                                           input logic [7:0] f6, input logic [7:0] f7,
                                           input logic [7:0] b8, input logic [7:0] b9);
    header_t h;
    h    = '0;
    h[0] = MAGIC_0;
    h[1] = MAGIC_1;
    h[2] = MAGIC_2;
    h[3] = MAGIC_3;
    h[4] = b4;
    h[5] = b5;
    h[6] = f6;
    h[7] = f7;
    h[8] = b8;
    h[9] = b9;
    return h;
  endfunction

  function automatic logic [7:0] bank_count();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'd0;
    if (r < 8) return 8'($urandom_range(1, 8));
    return 8'($urandom);
  endfunction

  function automatic logic [3:0] size_nibble();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 4'h0;
    if (r < 85) return 4'($urandom_range(1, 14));
    return EXP_NIB;
  endfunction

  function automatic header_t random_header();
    header_t h;
    int      kind;
    int      i;
    kind = $urandom_range(0, 99);
    if (kind < 4) begin
      for (i = 0; i < HDR_LEN; i++) h[i] = 8'($urandom);
      return h;
    end
    h = build_header(bank_count(), bank_count(), 8'($urandom), 8'($urandom), 8'($urandom),
                     8'($urandom));
    h[10] = 8'($urandom);
    h[11] = 8'($urandom);
    if (kind < 48) begin
      if ((h[7] & FMT_MASK) == FMT_NES2) h[7] = h[7] ^ 8'h08;
      if ($urandom_range(0, 3) == 0)
        for (i = 12; i < HDR_LEN; i++) h[i] = $urandom_range(0, 1) ? 8'($urandom) : 8'h00;
    end else begin
      h[7] = (h[7] & ~FMT_MASK) | FMT_NES2;
      h[9] = {size_nibble(), size_nibble()};
      for (i = 12; i < HDR_LEN; i++) h[i] = 8'($urandom);
    end
    if (kind >= 92) begin
      i = $urandom_range(0, 3);
      h[i] = h[i] ^ 8'($urandom_range(1, 255));
    end
    return h;
  endfunction

  function automatic logic [31:0] pick_file_size();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return $urandom;
    if (r == 1) return 32'hFFFF_FFFF;
    if (r == 2) return 32'($urandom_range(0, 16));
    // Land near typical small images so fits and misses both show up.
    return 32'd15 + 32'd16384 * $urandom_range(0, 8) + 32'd8192 * $urandom_range(0, 8)
           + 32'd512 * $urandom_range(0, 1) + 32'($urandom_range(0, 2));
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_beat(input logic [7:0] b, input logic restart);
    int gap;
    gap = steady_left > 0 ? 0 : pick_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push            <= 1'b1;
    header_byte     <= b;
    start_of_header <= restart;
    do @(posedge clk); while (full);
    @(negedge clk);
  endtask

  task automatic send_bytes(input header_t h, input int n);
    int i;
    for (i = 0; i < n; i++) send_beat(h[i], i == 0);
    beats_sent += n;
  endtask

  // Bytes past byte 15 without a restart are dropped by the block.
  task automatic send_trailing(input int n);
    int i;
    for (i = 0; i < n; i++) send_beat(8'($urandom), 1'b0);
  endtask

  task automatic set_file_size(input logic [31:0] v);
    push <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (6) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("tb_ines_header_decoder_top: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int gap;
    bit held;
    held = 1'b0;
    pop  = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_request && !held) begin
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        held = 1'b1;
      end else if ($urandom_range(0, 29) == 0) begin
        pop <= 1'b1;
        repeat (80) @(negedge clk);
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          pop <= 1'b0;
          repeat (gap) @(negedge clk);
        end
        pop <= 1'b1;
        @(negedge clk);
      end
    end
  end

  initial begin
    header_t h;
    int      phase_left;
    int      header_count;
    rst             = 1'b1;
    push            = 1'b0;
    header_byte     = '0;
    start_of_header = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    beats_sent      = 0;
    steady_left     = 0;
    hold_request    = 1'b0;
    phase_left      = 0;
    header_count    = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // file_size still at its reset value: too short
    send_bytes(build_header(8'd1, 8'd1, 8'h00, 8'h00, 8'h00, 8'h00), HDR_LEN);
    set_file_size(32'd0);
    send_bytes(build_header(8'd2, 8'd0, 8'h10, 8'h20, 8'h00, 8'h00), HDR_LEN);
    set_file_size(32'd15);
    send_bytes(build_header(8'd1, 8'd0, 8'hF1, 8'h40, 8'h00, 8'h00), HDR_LEN);
    set_file_size(32'd16);
    send_bytes(build_header(8'd0, 8'd0, 8'hF0, 8'hF8, 8'h0F, 8'h00), HDR_LEN);
    send_bytes(build_header(8'd0, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00), HDR_LEN);

    // header, trainer, one PRG and one CHR bank: exact fit, then one byte short
    set_file_size(32'd16 + 32'd512 + 32'd16384 + 32'd8192);
    send_bytes(build_header(8'd1, 8'd1, 8'h04, 8'h00, 8'h00, 8'h00), HDR_LEN);
    send_bytes(build_header(8'd1, 8'd1, 8'h04, FMT_NES2, 8'h00, 8'h00), HDR_LEN);
    set_file_size(32'd16 + 32'd512 + 32'd16384 + 32'd8192 - 32'd1);
    send_bytes(build_header(8'd1, 8'd1, 8'h04, 8'h00, 8'h00, 8'h00), HDR_LEN);

    set_file_size(32'hFFFF_FFFF);
    send_bytes(build_header(8'd0, 8'd255, 8'hFF, 8'hF3, 8'h00, 8'h00), HDR_LEN);
    h = build_header(8'd2, 8'd2, 8'hA1, 8'hB0, 8'h00, 8'h00);
    h[15] = 8'h01;
    send_bytes(h, HDR_LEN);
    h = build_header(8'd2, 8'd2, 8'h00, 8'h00, 8'h00, 8'h00);
    h[3] = 8'h1B;
    send_bytes(h, HDR_LEN);
    // exponent sizes: 2^31, 3 * 2^31, exponent 32, exponent 63
    send_bytes(build_header(8'h7C, 8'h00, 8'h00, 8'h28, 8'h01, 8'h0F), HDR_LEN);
    send_bytes(build_header(8'h7D, 8'h00, 8'h00, 8'h08, 8'h00, 8'h0F), HDR_LEN);
    send_bytes(build_header(8'h80, 8'h00, 8'h00, 8'h08, 8'h00, 8'h0F), HDR_LEN);
    send_bytes(build_header(8'h01, 8'hFF, 8'h00, 8'h08, 8'h00, 8'hF0), HDR_LEN);
    send_bytes(build_header(8'hFF, 8'hFF, 8'hF0, 8'hF8, 8'hFF, 8'hEE), HDR_LEN);
    // both sizes legal alone, together past 32 bits
    send_bytes(build_header(8'h7C, 8'h7C, 8'h00, 8'h08, 8'h00, 8'hFF), HDR_LEN);
    send_bytes('1, HDR_LEN);
    // restart mid-header, then trailing bytes that must be dropped
    h = build_header(8'd3, 8'd4, 8'h51, 8'h60, 8'h00, 8'h00);
    send_bytes('1, 5);
    send_bytes(h, HDR_LEN);
    send_trailing(3);

    while (beats_sent < ITEMS) begin
      if (phase_left == 0) begin
        set_file_size(pick_file_size());
        phase_left = $urandom_range(4, 12);
      end
      // Stop the receiver for a long stretch and push hard so the block backs up.
      if (header_count == 12) begin
        hold_request = 1'b1;
        steady_left  = 25;
      end else if (steady_left == 0 && $urandom_range(0, 19) == 0) begin
        steady_left = $urandom_range(2, 6);
      end
      if ($urandom_range(0, 9) == 0) send_bytes(random_header(), $urandom_range(1, 15));
      send_bytes(random_header(), HDR_LEN);
      if ($urandom_range(0, 9) == 0) send_trailing($urandom_range(1, 4));
      if (steady_left > 0) steady_left--;
      phase_left--;
      header_count++;
    end

    push <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (errors == 0) begin
      $display("tb_ines_header_decoder_top: clean");
    end else begin
      $display("tb_ines_header_decoder_top: errors");
    end
    $finish;
  end

endmodule
